[hdl/assert_macros.svh]
// Assertion macros used by the RTL top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define ASSERT_IMPLIES(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled during reset
`define ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

[hdl/rwfs_pkg.sv]
// Types, constants and helpers for the rolling window fingerprint sampler
`default_nettype none
package rwfs_pkg;

  typedef enum logic [2:0] {
    REG_PRIME            = 3'd0,
    REG_HASH_BITS        = 3'd1,
    REG_SAMPLE_BITS      = 3'd2,
    REG_WIN_SIZE         = 3'd3,
    REG_WINDOW_POWER     = 3'd4,
    REG_MAX_PAYLOAD      = 3'd5,
    REG_MAX_FINGERPRINTS = 3'd6
  } cfg_reg_t;

  localparam logic [63:0] PRIME_RESET         = 64'd1048583;
  localparam logic [6:0]  HASH_BITS_RESET     = 7'd60;
  localparam logic [5:0]  SAMPLE_BITS_RESET   = 6'd7;
  localparam logic [6:0]  WIN_SIZE_RESET      = 7'd64;
  localparam logic [63:0] WINDOW_POWER_RESET  = 64'd0;
  localparam logic [15:0] MAX_PAYLOAD_RESET   = 16'd1464;
  localparam logic [11:0] MAX_FP_RESET        = 12'd1000;
  localparam logic [11:0] TESTED_SAT          = 12'd4095;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;
  localparam int FIFO_CW    = 3;

  typedef struct packed {
    logic        active;
    logic        restart;
    logic        need_sub;
    logic        first_win;
    logic        cand;
    logic [15:0] offset;
  } item_ctl_t;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } pipe_state_t;

  typedef struct packed {
    logic [63:0] fingerprint;
    logic [15:0] window_offset;
  } result_t;

  function automatic logic [63:0] low_mask(input logic [6:0] n);
    logic [63:0] m;
    if (n >= 7'd64) begin
      m = '1;
    end else begin
      m = (64'd1 << n) - 64'd1;
    end
    return m;
  endfunction

endpackage
`default_nettype wire

[hdl/rwfs_if.sv]
// Channel interfaces: payload bytes, results and register writes
`default_nettype none
interface rwfs_byte_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic        first_byte;
  logic [15:0] payload_length;

  modport source (output valid, data_byte, first_byte, payload_length, input ready);
  modport sink (input valid, data_byte, first_byte, payload_length, output ready);
endinterface

interface rwfs_result_if;
  logic        valid;
  logic        ready;
  logic [63:0] fingerprint;
  logic [15:0] window_offset;

  modport source (output valid, fingerprint, window_offset, input ready);
  modport sink (input valid, fingerprint, window_offset, output ready);
endinterface

interface rwfs_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

[hdl/rwfs_window_ram.sv]
// Byte window store: one write port, one registered read port, read-first
`default_nettype none
module rwfs_window_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [7:0]    wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule
`default_nettype wire

[hdl/rwfs_hash_core.sv]
// Rolling hash datapath: partial products, leaving-byte term, hash update
`default_nettype none
module rwfs_hash_core (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                issue,
  input  wire rwfs_pkg::item_ctl_t ctl_in,
  input  wire logic [7:0]          byte_in,
  input  wire logic [7:0]          leave_byte,
  input  wire logic [63:0]         prime,
  input  wire logic [63:0]         window_power,
  input  wire logic [63:0]         hmask,
  output logic [63:0]              hash,
  output rwfs_pkg::pipe_state_t    occ,
  output rwfs_pkg::item_ctl_t      ctl_out
);

  logic                v1, v2, v3;
  rwfs_pkg::item_ctl_t ctl1, ctl2, ctl3;
  logic [7:0]          byte1;
  logic [8:0]          term2;
  logic [63:0]         sub2;
  logic [63:0]         pp0;
  logic [31:0]         pp1, pp2;
  logic [63:0]         rolling_hash;

  logic [63:0] op;
  logic [63:0] pp0_c;
  logic [31:0] pp1_c, pp2_c;
  logic [8:0]  leave9;
  logic [72:0] sub_full;
  logic [63:0] sum_c;

  always_comb begin
    op       = ctl1.restart ? 64'd0 : rolling_hash;
    pp0_c    = op[31:0] * prime[31:0];
    pp1_c    = op[31:0] * prime[63:32];
    pp2_c    = op[63:32] * prime[31:0];
    leave9   = {1'b0, leave_byte} + 9'd1;
    sub_full = leave9 * window_power;
    sum_c    = pp0 + {pp1 + pp2, 32'd0} + {55'd0, term2} - sub2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1           <= 1'b0;
      v2           <= 1'b0;
      v3           <= 1'b0;
      rolling_hash <= 64'd0;
    end else begin
      v1 <= issue;
      v2 <= v1;
      v3 <= v2;
      if (v2 && ctl2.active) begin
        rolling_hash <= sum_c & hmask;
      end
    end
  end

  always_ff @(posedge clk) begin
    ctl1  <= ctl_in;
    byte1 <= byte_in;
    ctl2  <= ctl1;
    term2 <= {1'b0, byte1} + 9'd1;
    sub2  <= ctl1.need_sub ? sub_full[63:0] : 64'd0;
    pp0   <= pp0_c;
    pp1   <= pp1_c;
    pp2   <= pp2_c;
    ctl3  <= ctl2;
  end

  assign hash    = rolling_hash;
  assign occ     = '{s1: v1, s2: v2, s3: v3};
  assign ctl_out = ctl3;

endmodule
`default_nettype wire

[hdl/rwfs_result_fifo.sv]
// Small show-ahead result queue between the hash pipeline and the output
`default_nettype none
module rwfs_result_fifo (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          push,
  input  wire rwfs_pkg::result_t             push_data,
  input  wire logic                          pop,
  output logic                               out_valid,
  output rwfs_pkg::result_t                  out_data,
  output logic [rwfs_pkg::FIFO_CW-1:0]       count
);

  rwfs_pkg::result_t                slots [rwfs_pkg::FIFO_DEPTH];
  logic [rwfs_pkg::FIFO_AW-1:0]     wr_ptr, rd_ptr;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  assign out_valid = (count != '0);
  assign out_data  = slots[rd_ptr];

endmodule
`default_nettype wire

[hdl/rolling_window_fingerprint_sampler_unit.sv]
// Top level of the rolling window fingerprint sampler
// Path: a byte's result passes hash-core stages s1, s2, s3, then the result queue.
// Pacing: no byte is taken while one sits in s1, set by the rolling-hash loop (64-bit
//   multiply split into 32-bit partial products, then a summing step that writes the hash).
// Reset (rst, synchronous): registers take their reset values, packet state clears,
//   the result queue empties; the window memory is not cleared.
`default_nettype none
`include "assert_macros.svh"
module rolling_window_fingerprint_sampler_unit #(
  parameter int WINDOW_MAX = 64
) (
  input wire logic        clk,
  input wire logic        rst,
  rwfs_byte_if.sink       payload,
  rwfs_result_if.source   result,
  rwfs_cfg_if.sink        cfg
);

  localparam int          AW     = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam logic [15:0] WMAX16 = 16'(WINDOW_MAX);

  // configuration registers
  logic [63:0] prime;
  logic [6:0]  hash_bits;
  logic [5:0]  sample_bits;
  logic [6:0]  win_size;
  logic [63:0] window_power;
  logic [15:0] max_payload;
  logic [11:0] max_fingerprints;

  // packet state
  logic [15:0]   byte_position;
  logic [15:0]   packet_length;
  logic          packet_eligible;
  logic [AW-1:0] wr_ptr;
  logic [11:0]   tested_count;

  logic [15:0]         w_eff;
  logic                take;
  logic                first;
  logic [15:0]         len_sel, pos_sel;
  logic                elig_sel, active;
  logic [AW-1:0]       ptr_sel, ptr_next;
  logic [15:0]         rd_sum, rd_wrap;
  rwfs_pkg::item_ctl_t ctl_in;

  logic [7:0]                     leave_byte;
  logic [63:0]                    hash;
  rwfs_pkg::pipe_state_t          occ;
  rwfs_pkg::item_ctl_t            h_ctl;
  logic [63:0]                    hmask, smask;
  logic [11:0]                    tested_base;
  logic                           emit;
  logic                           pop;
  logic                           fifo_valid;
  rwfs_pkg::result_t              fifo_data;
  rwfs_pkg::result_t              push_data;
  logic [rwfs_pkg::FIFO_CW-1:0]   fifo_count;
  logic [3:0]                     slots_used;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      prime            <= rwfs_pkg::PRIME_RESET;
      hash_bits        <= rwfs_pkg::HASH_BITS_RESET;
      sample_bits      <= rwfs_pkg::SAMPLE_BITS_RESET;
      win_size         <= rwfs_pkg::WIN_SIZE_RESET;
      window_power     <= rwfs_pkg::WINDOW_POWER_RESET;
      max_payload      <= rwfs_pkg::MAX_PAYLOAD_RESET;
      max_fingerprints <= rwfs_pkg::MAX_FP_RESET;
    end else if (cfg.valid && cfg.ready) begin
      unique case (rwfs_pkg::cfg_reg_t'(cfg.index))
        rwfs_pkg::REG_PRIME:            prime            <= cfg.data;
        rwfs_pkg::REG_HASH_BITS:        hash_bits        <= cfg.data[6:0];
        rwfs_pkg::REG_SAMPLE_BITS:      sample_bits      <= cfg.data[5:0];
        rwfs_pkg::REG_WIN_SIZE:         win_size         <= cfg.data[6:0];
        rwfs_pkg::REG_WINDOW_POWER:     window_power     <= cfg.data;
        rwfs_pkg::REG_MAX_PAYLOAD:      max_payload      <= cfg.data[15:0];
        rwfs_pkg::REG_MAX_FINGERPRINTS: max_fingerprints <= cfg.data[11:0];
        default: begin
        end
      endcase
    end
  end

  // byte admission
  always_comb begin
    priority if (win_size == 7'd0) begin
      w_eff = 16'd1;
    end else if ({9'd0, win_size} > WMAX16) begin
      w_eff = WMAX16;
    end else begin
      w_eff = {9'd0, win_size};
    end

    hmask = rwfs_pkg::low_mask(hash_bits);
    smask = rwfs_pkg::low_mask({1'b0, sample_bits});

    slots_used    = {1'b0, fifo_count} + {3'd0, occ.s2} + {3'd0, occ.s3};
    payload.ready = !occ.s1 && (slots_used < 4'(rwfs_pkg::FIFO_DEPTH));
    take          = payload.valid && payload.ready;
    first         = payload.first_byte;

    len_sel  = first ? payload.payload_length : packet_length;
    pos_sel  = first ? 16'd0 : byte_position;
    elig_sel = first ? ((payload.payload_length >= w_eff) &&
                        (payload.payload_length <= max_payload))
                     : packet_eligible;
    ptr_sel  = first ? '0 : wr_ptr;
    active   = elig_sel && (pos_sel < len_sel);

    ptr_next = ({{(16-AW){1'b0}}, ptr_sel} + 16'd1 == WMAX16) ? '0 : ptr_sel + 1'b1;
    rd_sum   = {{(16-AW){1'b0}}, ptr_sel} + WMAX16 - w_eff;
    rd_wrap  = (rd_sum >= WMAX16) ? rd_sum - WMAX16 : rd_sum;

    ctl_in.active    = active;
    ctl_in.restart   = first;
    ctl_in.need_sub  = active && (pos_sel >= w_eff);
    ctl_in.first_win = active && (pos_sel + 16'd1 == w_eff);
    ctl_in.cand      = active && (pos_sel >= w_eff) && (pos_sel + 16'd1 < len_sel);
    ctl_in.offset    = pos_sel + 16'd1 - w_eff;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position   <= 16'd0;
      packet_length   <= 16'd0;
      packet_eligible <= 1'b0;
      wr_ptr          <= '0;
    end else if (take) begin
      packet_length   <= len_sel;
      packet_eligible <= elig_sel;
      byte_position   <= active ? pos_sel + 16'd1 : pos_sel;
      wr_ptr          <= active ? ptr_next : ptr_sel;
    end
  end

  rwfs_window_ram #(
    .DEPTH (WINDOW_MAX),
    .AW    (AW)
  ) u_window_ram (
    .clk   (clk),
    .we    (take && active),
    .waddr (ptr_sel),
    .wdata (payload.data_byte),
    .re    (take),
    .raddr (rd_wrap[AW-1:0]),
    .rdata (leave_byte)
  );

  rwfs_hash_core u_hash_core (
    .clk          (clk),
    .rst          (rst),
    .issue        (take),
    .ctl_in       (ctl_in),
    .byte_in      (payload.data_byte),
    .leave_byte   (leave_byte),
    .prime        (prime),
    .window_power (window_power),
    .hmask        (hmask),
    .hash         (hash),
    .occ          (occ),
    .ctl_out      (h_ctl)
  );

  // sampling decision
  always_comb begin
    tested_base = h_ctl.restart ? 12'd0 : tested_count;
    emit        = occ.s3 && (h_ctl.first_win ||
                  (h_ctl.cand && ((hash & smask) == 64'd0) &&
                   (tested_base < max_fingerprints)));
    push_data.fingerprint   = hash;
    push_data.window_offset = h_ctl.offset;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tested_count <= 12'd0;
    end else if (occ.s3) begin
      if (emit && (tested_base != rwfs_pkg::TESTED_SAT)) begin
        tested_count <= tested_base + 12'd1;
      end else begin
        tested_count <= tested_base;
      end
    end
  end

  assign pop = result.valid && result.ready;

  rwfs_result_fifo u_result_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (emit),
    .push_data (push_data),
    .pop       (pop),
    .out_valid (fifo_valid),
    .out_data  (fifo_data),
    .count     (fifo_count)
  );

  assign result.valid         = fifo_valid;
  assign result.fingerprint   = fifo_data.fingerprint;
  assign result.window_offset = fifo_data.window_offset;

  `ASSERT_NEXT(a_byte_spacing, clk, rst, payload.valid && payload.ready, !payload.ready)
  `ASSERT_IMPLIES(a_queue_room, clk, rst, emit, (fifo_count < 3'(rwfs_pkg::FIFO_DEPTH)) || pop)
  `ASSERT_IMPLIES(a_pos_bound, clk, rst, packet_eligible, byte_position <= packet_length)

endmodule
`default_nettype wire

[verif/tb.sv]
// Self-checking testbench for the rolling window fingerprint sampler unit
`timescale 1ns / 1ps
module tb;

  localparam int WIN_MAX   = 64;
  localparam int DRAIN_PAD = 16;

  typedef struct {
    logic [63:0] prime;
    logic [6:0]  hash_bits;
    logic [5:0]  sample_bits;
    logic [6:0]  win_len;
    logic [63:0] win_pow;
    logic [15:0] max_pay;
    logic [11:0] max_fp;
  } sampler_cfg_t;

  logic clk;
  logic rst;

  rwfs_byte_if   pay_if ();
  rwfs_result_if res_if ();
  rwfs_cfg_if    cfg_if ();

  rolling_window_fingerprint_sampler_unit #(
    .WINDOW_MAX(WIN_MAX)
  ) uut (
    .clk(clk),
    .rst(rst),
    .payload(pay_if),
    .result(res_if),
    .cfg(cfg_if)
  );

  // register copy and window state of the fingerprint predictor
  sampler_cfg_t cfg_now = '{rwfs_pkg::PRIME_RESET, rwfs_pkg::HASH_BITS_RESET,
                            rwfs_pkg::SAMPLE_BITS_RESET, rwfs_pkg::WIN_SIZE_RESET,
                            rwfs_pkg::WINDOW_POWER_RESET, rwfs_pkg::MAX_PAYLOAD_RESET,
                            rwfs_pkg::MAX_FP_RESET};
  logic [7:0]  win_mem [WIN_MAX];
  logic [63:0] cur_hash = '0;
  logic [15:0] cur_pos  = '0;
  logic [15:0] cur_len  = '0;
  logic [11:0] fp_count = '0;
  logic        pkt_on   = 1'b0;

  rwfs_pkg::result_t pending_fps[$];

  int err_cnt      = 0;
  int bytes_sent   = 0;
  int bytes_hashed = 0;
  int fps_seen     = 0;
  int n_settings   = 0;
  bit tx_bursty    = 1'b1;
  int burst_left   = 0;
  int rx_hold_req  = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic logic [63:0] hash_mask(input logic [6:0] n);
    return (n >= 7'd64) ? {64{1'b1}} : ~({64{1'b1}} << n);
  endfunction

  function automatic int unsigned eff_window(input logic [6:0] wl);
    if (wl == 7'd0) return 1;
    if (wl > WIN_MAX) return WIN_MAX;
    return wl;
  endfunction

  function automatic sampler_cfg_t make_settings(input logic [63:0] p, input logic [6:0] hb,
                                                 input logic [5:0] sb, input logic [6:0] wl,
                                                 input logic [15:0] mp, input logic [11:0] mf);
    sampler_cfg_t s;
    logic [63:0] pw;
    s.prime = p;
    s.hash_bits = hb;
    s.sample_bits = sb;
    s.win_len = wl;
    s.max_pay = mp;
    s.max_fp = mf;
    pw = 64'd1;
    repeat (eff_window(wl)) pw = pw * p;
    s.win_pow = pw & hash_mask(hb);
    return s;
  endfunction

  // Advances the rolling hash by one byte; returns 1 when the byte was hashed.
  function automatic bit roll_window_hash(input logic [7:0] b, input logic first,
                                          input logic [15:0] len);
    int unsigned w;
    int unsigned pos;
    logic [63:0] h;
    rwfs_pkg::result_t r;
    w = eff_window(cfg_now.win_len);
    if (first) begin
      cur_len  = len;
      cur_pos  = '0;
      cur_hash = '0;
      fp_count = '0;
      pkt_on   = (len >= w) && (len <= cfg_now.max_pay);
    end
    pos = cur_pos;
    if (!pkt_on || pos >= cur_len) return 1'b0;
    h = cur_hash * cfg_now.prime + {56'd0, b} + 64'd1;
    if (pos >= w) h = h - ({56'd0, win_mem[(pos - w) % WIN_MAX]} + 64'd1) * cfg_now.win_pow;
    h = h & hash_mask(cfg_now.hash_bits);
    cur_hash = h;
    win_mem[pos % WIN_MAX] = b;
    r.fingerprint = h;
    if (pos + 1 == w) begin
      r.window_offset = '0;
      pending_fps.push_back(r);
      if (fp_count != rwfs_pkg::TESTED_SAT) fp_count++;
    end else if (pos >= w && (h & hash_mask({1'b0, cfg_now.sample_bits})) == '0 &&
                 pos + 1 < cur_len && fp_count < cfg_now.max_fp) begin
      r.window_offset = 16'(pos + 1 - w);
      pending_fps.push_back(r);
      if (fp_count != rwfs_pkg::TESTED_SAT) fp_count++;
    end
    if (cur_pos != 16'hFFFF) cur_pos++;
    return 1'b1;
  endfunction

  task automatic send_byte(input logic [7:0] data, input logic first, input logic [15:0] len);
    int gap;
    gap = 0;
    if (tx_bursty) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 24) : $urandom_range(1, 6);
      end
      burst_left--;
    end
    if (gap > 0) begin
      pay_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pay_if.valid <= 1'b1;
    pay_if.data_byte <= data;
    pay_if.first_byte <= first;
    pay_if.payload_length <= len;
    @(posedge clk);
    while (!pay_if.ready) @(posedge clk);
    bytes_sent++;
    if (roll_window_hash(data, first, len)) bytes_hashed++;
  endtask

  task automatic send_packet(input logic [15:0] len, input int unsigned n);
    for (int unsigned i = 0; i < n; i++)
      send_byte(8'($urandom), i == 0, (i == 0) ? len : 16'($urandom));
  endtask

  // sender stops and waits for every outstanding fingerprint, then for the pipeline
  task automatic wait_idle();
    pay_if.valid <= 1'b0;
    while (pending_fps.size() != 0) @(posedge clk);
    repeat (DRAIN_PAD) @(posedge clk);
  endtask

  task automatic write_reg(input rwfs_pkg::cfg_reg_t idx, input logic [63:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= val;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    case (idx)
      rwfs_pkg::REG_PRIME:            cfg_now.prime = val;
      rwfs_pkg::REG_HASH_BITS:        cfg_now.hash_bits = val[6:0];
      rwfs_pkg::REG_SAMPLE_BITS:      cfg_now.sample_bits = val[5:0];
      rwfs_pkg::REG_WIN_SIZE:         cfg_now.win_len = val[6:0];
      rwfs_pkg::REG_WINDOW_POWER:     cfg_now.win_pow = val;
      rwfs_pkg::REG_MAX_PAYLOAD:      cfg_now.max_pay = val[15:0];
      rwfs_pkg::REG_MAX_FINGERPRINTS: cfg_now.max_fp = val[11:0];
      default: ;
    endcase
  endtask

  // narrow registers get junk above their width; only the low bits count
  task automatic load_settings(input sampler_cfg_t s);
    logic [63:0] noise;
    noise = {$urandom, $urandom};
    write_reg(rwfs_pkg::REG_PRIME, s.prime);
    write_reg(rwfs_pkg::REG_HASH_BITS, {noise[63:7], s.hash_bits});
    write_reg(rwfs_pkg::REG_SAMPLE_BITS, {noise[63:6], s.sample_bits});
    write_reg(rwfs_pkg::REG_WIN_SIZE, {noise[63:7], s.win_len});
    write_reg(rwfs_pkg::REG_WINDOW_POWER, s.win_pow);
    write_reg(rwfs_pkg::REG_MAX_PAYLOAD, {noise[63:16], s.max_pay});
    write_reg(rwfs_pkg::REG_MAX_FINGERPRINTS, {noise[63:12], s.max_fp});
    cfg_if.valid <= 1'b0;
    n_settings++;
  endtask

  // mostly whole payloads, some cut short, overrun, oversized or too short
  task automatic run_traffic(input int n, input int len_lo, input int len_hi);
    int start;
    int kind;
    int len;
    start = bytes_hashed;
    while (bytes_hashed - start < n) begin
      kind = $urandom_range(0, 9);
      tx_bursty = ($urandom_range(0, 3) != 0);
      len = $urandom_range(len_lo, len_hi);
      if (kind < 7) send_packet(len, len);
      else if (kind == 7) send_packet(len, $urandom_range(1, len));
      else if (kind == 8) send_packet(len, len + $urandom_range(1, 3));
      else if ($urandom_range(0, 1) == 0) send_packet($urandom_range(0, 65535),
                                                      $urandom_range(1, 4));
      else send_packet($urandom_range(0, len_lo), $urandom_range(1, 3));
    end
    tx_bursty = 1'b1;
  endtask

  task automatic test_stray_bytes();
    repeat (3) send_byte(8'($urandom), 1'b0, 16'hFFFF);
    wait_idle();
  endtask

  task automatic test_directed_edges();
    logic [7:0] pat [10];
    pat = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'h80, 8'h7F, 8'h01, 8'hFE, 8'hAA, 8'h55};
    load_settings(make_settings(64'd31, 7'd16, 6'd1, 7'd4, 16'd12, 12'd3));
    send_packet(16'd3, 3);
    for (int i = 0; i < 10; i++) send_byte(pat[i], i == 0, (i == 0) ? 16'd8 : 16'h0000);
    send_packet(16'd13, 2);
    send_packet(16'hFFFF, 1);
    send_packet(16'd0, 1);
    for (int i = 0; i < 12; i++) send_byte(8'h00, i == 0, 16'd12);
    wait_idle();
  endtask

  task automatic test_reset_defaults();
    sampler_cfg_t s;
    s = make_settings(rwfs_pkg::PRIME_RESET, rwfs_pkg::HASH_BITS_RESET,
                      rwfs_pkg::SAMPLE_BITS_RESET, rwfs_pkg::WIN_SIZE_RESET,
                      rwfs_pkg::MAX_PAYLOAD_RESET, rwfs_pkg::MAX_FP_RESET);
    s.win_pow = rwfs_pkg::WINDOW_POWER_RESET;
    load_settings(s);
    run_traffic(300, 64, 80);
    wait_idle();
  endtask

  task automatic test_full_width_hash();
    load_settings(make_settings({$urandom, $urandom}, 7'd64, 6'd2, 7'd64, 16'hFFFF, 12'hFFF));
    run_traffic(250, 64, 90);
    wait_idle();
  endtask

  task automatic test_cap_zero();
    load_settings(make_settings({64{1'b1}}, 7'd1, 6'd0, 7'd1, 16'd40, 12'd0));
    run_traffic(150, 1, 42);
    wait_idle();
  endtask

  task automatic test_window_clamps();
    sampler_cfg_t s;
    load_settings(make_settings(64'd257, 7'd0, 6'd63, 7'd0, 16'd30, 12'd5));
    run_traffic(120, 1, 32);
    wait_idle();
    s = make_settings({$urandom, $urandom}, 7'd127, 6'd63, 7'd100, 16'd90, 12'hFFF);
    s.win_pow = {$urandom, $urandom};
    load_settings(s);
    run_traffic(200, 64, 92);
    wait_idle();
  endtask

  task automatic test_random_settings();
    sampler_cfg_t s;
    int w;
    for (int r = 0; r < 5; r++) begin
      w = $urandom_range(1, 16);
      s = make_settings({$urandom, $urandom}, $urandom_range(4, 24), $urandom_range(0, 3), w,
                        w + $urandom_range(6, 40),
                        ($urandom_range(0, 2) == 0) ? 12'hFFF : 12'($urandom_range(1, 12)));
      if ($urandom_range(0, 3) == 0) s.win_pow = {$urandom, $urandom};
      load_settings(s);
      run_traffic(150, w, s.max_pay + 2);
      wait_idle();
    end
  endtask

  task automatic test_unfingerprinted();
    load_settings(make_settings(64'd7, 7'd12, 6'd0, 7'd2, 16'd0, 12'd10));
    repeat (3) send_packet($urandom_range(0, 8), $urandom_range(2, 6));
    wait_idle();
  endtask

  // long result stall with the sender pushing, then a sender pause mid-payload
  task automatic test_backpressure();
    load_settings(make_settings(64'd131, 7'd8, 6'd0, 7'd2, 16'd200, 12'hFFF));
    tx_bursty = 1'b0;
    rx_hold_req = 150;
    send_packet(16'd60, 60);
    send_packet(16'd40, 20);
    wait_idle();
    for (int i = 0; i < 20; i++) send_byte(8'($urandom), 1'b0, 16'($urandom));
    tx_bursty = 1'b1;
    wait_idle();
  endtask

  initial begin : result_checker
    rwfs_pkg::result_t want;
    logic [15:0] rx_pat;
    int hold_left;
    int cyc;
    rx_pat = 16'hFFFF;
    hold_left = 0;
    cyc = 0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (res_if.valid && res_if.ready) begin
        fps_seen++;
        if (pending_fps.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected transfer, fingerprint %h offset %0d", $time,
                   res_if.fingerprint, res_if.window_offset);
        end else begin
          want = pending_fps.pop_front();
          if (res_if.fingerprint !== want.fingerprint) begin
            err_cnt++;
            $display("%0t: fingerprint expected %h actual %h", $time, want.fingerprint,
                     res_if.fingerprint);
          end
          if (res_if.window_offset !== want.window_offset) begin
            err_cnt++;
            $display("%0t: window_offset expected %0d actual %0d", $time, want.window_offset,
                     res_if.window_offset);
          end
        end
      end
      if (rx_hold_req > 0) begin
        hold_left = rx_hold_req;
        rx_hold_req = 0;
      end
      cyc++;
      if (cyc % 48 == 0) begin
        case ($urandom_range(0, 3))
          0: rx_pat = '1;
          1: rx_pat = 16'($urandom);
          2: rx_pat = 16'($urandom | $urandom);
          default: rx_pat = 16'($urandom & $urandom);
        endcase
      end
      if (hold_left > 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= rx_pat[0];
        rx_pat = {rx_pat[0], rx_pat[15:1]};
      end
    end
  end

  initial begin
    pay_if.valid <= 1'b0;
    pay_if.data_byte <= '0;
    pay_if.first_byte <= 1'b0;
    pay_if.payload_length <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.index <= rwfs_pkg::REG_PRIME;
    cfg_if.data <= '0;
    rst <= 1'b1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_stray_bytes();
    test_directed_edges();
    test_reset_defaults();
    test_full_width_hash();
    test_cap_zero();
    test_window_clamps();
    test_random_settings();
    test_unfingerprinted();
    test_backpressure();

    repeat (DRAIN_PAD) @(posedge clk);
    if (pending_fps.size() != 0) begin
      err_cnt++;
      $display("%0t: %0d fingerprints never arrived", $time, pending_fps.size());
    end
    $display("Sent %0d payload bytes, %0d of them hashed, across %0d register settings.",
             bytes_sent, bytes_hashed, n_settings);
    $display("Checked %0d fingerprint transfers; %0d mismatches.", fps_seen, err_cnt);
    if (err_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
